>>> rtl/arwc_pkg.sv
// ----------------------------------------------------------------------------
// arwc_pkg: shared constants for the anti-replay window check
// Widths of the counter and bitmap words, default ring size, window size
// and the verdict codes.
// ----------------------------------------------------------------------------
package arwc_pkg;

    localparam int CTR_W           = 64;          // packet counter width
    localparam int BITMAP_W        = 64;          // bits per ring word
    localparam int BIT_W           = 6;           // log2 of BITMAP_W
    localparam int WNUM_W          = CTR_W - BIT_W; // word number width
    localparam int VERDICT_W       = 3;
    localparam int RING_WORDS_DEF  = 32;
    localparam int WINDOW_SIZE     = 1984;
    localparam int MOD_STEPS       = 8;           // remainder bits per cycle

    typedef logic [VERDICT_W-1:0] verdict_t;

    localparam verdict_t VERDICT_FIRST     = 3'd0;
    localparam verdict_t VERDICT_NEW_HIGH  = 3'd1;
    localparam verdict_t VERDICT_IN_WINDOW = 3'd2;
    localparam verdict_t VERDICT_TOO_OLD   = 3'd3;
    localparam verdict_t VERDICT_DUPLICATE = 3'd4;

endpackage

>>> rtl/arwc_req_if.sv
// ----------------------------------------------------------------------------
// arwc_req_if: packet counter channel
// Valid/ready channel that carries one packet counter per transaction.
// ----------------------------------------------------------------------------
interface arwc_req_if import arwc_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [CTR_W-1:0] packet_counter;

    modport source (output valid, output packet_counter, input ready);
    modport sink   (input valid, input packet_counter, output ready);

endinterface

>>> rtl/arwc_rsp_if.sv
// ----------------------------------------------------------------------------
// arwc_rsp_if: verdict channel
// Valid/ready channel that carries the accept flag and verdict code.
// ----------------------------------------------------------------------------
interface arwc_rsp_if import arwc_pkg::*; ();

    logic     valid;
    logic     ready;
    logic     accepted;
    verdict_t verdict;

    modport source (output valid, output accepted, output verdict, input ready);
    modport sink   (input valid, input accepted, input verdict, output ready);

endinterface

>>> rtl/arwc_ram.sv
// ----------------------------------------------------------------------------
// arwc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents are not reset.
// ----------------------------------------------------------------------------
module arwc_ram import arwc_pkg::*;
#(
    parameter int WIDTH = BITMAP_W,
    parameter int DEPTH = RING_WORDS_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/anti_replay_window_check_unit.sv
// ----------------------------------------------------------------------------
// anti_replay_window_check_unit: sliding-window replay filter
// Flow: a too-old packet goes from S_CLASS to S_DONE; an in-window packet
//   tests and sets its bit in S_READ, S_RMW; the first sets it in S_MARK; a
//   new high in the top's word goes S_SPAN, S_READ, S_RMW, else S_SPAN, S_SWEEP
//   (zeroes crossed ring words), S_MARK. A non-power-of-two ring adds S_MOD
//   (word index remainder, 8 bits a cycle) but not for too-old packets. No
//   overlap: the next is taken as the verdict loads. Reset: ready low in S_INIT.
// Description: keeps the highest accepted counter and a ring bitmap of
//   64-bit words in RAM, and answers accept or reject for each counter.
// ----------------------------------------------------------------------------
module anti_replay_window_check_unit import arwc_pkg::*;
#(
    parameter int RING_WORDS = RING_WORDS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    arwc_req_if.sink   req,
    arwc_rsp_if.source rsp
);

    // ------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------
    localparam int IDX_W     = $clog2(RING_WORDS);
    localparam int CNT_W     = IDX_W + 1;          // holds RING_WORDS itself
    localparam int EXT_W     = IDX_W + 1;          // remainder plus one bit
    localparam int MOD_ITERS = CTR_W / MOD_STEPS;
    localparam int MCNT_W    = $clog2(MOD_ITERS);
    localparam bit RING_POW2 = (RING_WORDS & (RING_WORDS - 1)) == 0;

    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(RING_WORDS - 1);
    localparam logic [MCNT_W-1:0] LAST_MCNT = MCNT_W'(MOD_ITERS - 1);

    typedef enum logic [3:0] {
        S_INIT,     // zero the ring after reset
        S_IDLE,
        S_CLASS,    // compare against the top counter
        S_MOD,      // word number modulo ring size
        S_SPAN,     // size the clearing sweep
        S_SWEEP,    // zero crossed ring words
        S_READ,     // read the ring word
        S_RMW,      // test and set the bit
        S_MARK,     // write the new top's bit into a cleared word
        S_DONE      // hand the verdict to the output register
    } state_t;

    typedef enum logic [1:0] {
        K_FIRST,
        K_HIGH,
        K_WIN
    } kind_t;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t              state_reg,       state_next;
    kind_t               kind_reg,        kind_next;
    logic [CTR_W-1:0]    ctr_reg,         ctr_next;
    logic [CTR_W-1:0]    top_reg,         top_next;
    logic [IDX_W-1:0]    top_idx_reg,     top_idx_next;
    logic                started_reg,     started_next;
    logic [IDX_W-1:0]    idx_reg,         idx_next;
    logic [WNUM_W-1:0]   span_reg,        span_next;
    logic [IDX_W-1:0]    sw_idx_reg,      sw_idx_next;
    logic [CNT_W-1:0]    sw_cnt_reg,      sw_cnt_next;
    logic [CTR_W-1:0]    mod_sh_reg,      mod_sh_next;
    logic [IDX_W-1:0]    mod_rem_reg,     mod_rem_next;
    logic [MCNT_W-1:0]   mod_cnt_reg,     mod_cnt_next;
    logic                res_acc_reg,     res_acc_next;
    verdict_t            res_verdict_reg, res_verdict_next;
    logic                rsp_valid_reg,   rsp_valid_next;
    logic                rsp_acc_reg,     rsp_acc_next;
    verdict_t            rsp_verdict_reg, rsp_verdict_next;

    // ------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------
    logic [WNUM_W-1:0]   ctr_word;
    logic [WNUM_W-1:0]   top_word;
    logic [CTR_W-1:0]    age;
    logic                too_old;
    logic [BITMAP_W-1:0] bit_sel;
    logic [IDX_W-1:0]    sw_idx_inc;
    logic [IDX_W-1:0]    mod_rem_step;
    logic [CTR_W-1:0]    mod_sh_step;
    logic                out_free;
    logic                req_fire;

    logic                ram_wr_en;
    logic [IDX_W-1:0]    ram_wr_addr;
    logic [BITMAP_W-1:0] ram_wr_data;
    logic                ram_rd_en;
    logic [BITMAP_W-1:0] ram_rd_data;

    assign ctr_word   = ctr_reg[CTR_W-1:BIT_W];
    assign top_word   = top_reg[CTR_W-1:BIT_W];
    assign age        = top_reg - ctr_reg;
    assign too_old    = age >= CTR_W'(WINDOW_SIZE);
    assign bit_sel    = BITMAP_W'(1) << ctr_reg[BIT_W-1:0];
    assign sw_idx_inc = (sw_idx_reg == LAST_IDX) ? '0 : sw_idx_reg + 1'b1;

    // Output register frees up when empty or being taken this cycle
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) || ((state_reg == S_DONE) && out_free);
    assign req_fire  = req.valid && req.ready;

    assign rsp.valid    = rsp_valid_reg;
    assign rsp.accepted = rsp_acc_reg;
    assign rsp.verdict  = rsp_verdict_reg;

    // Restoring remainder: take MOD_STEPS word-number bits per cycle, MSB first
    always_comb
    begin : mod_step
        logic [IDX_W-1:0] r;
        logic [EXT_W-1:0] ext;
        logic [CTR_W-1:0] sh;
        r  = mod_rem_reg;
        sh = mod_sh_reg;
        for (int k = 0; k < MOD_STEPS; k++)
        begin
            ext = {r, sh[CTR_W-1]};
            sh  = sh << 1;
            if (ext >= EXT_W'(RING_WORDS))
            begin
                ext = ext - EXT_W'(RING_WORDS);
            end
            r = ext[IDX_W-1:0];
        end
        mod_rem_step = r;
        mod_sh_step  = sh;
    end

    // Where to go once the ring index of the counter is known
    function automatic state_t route(input kind_t k);
        state_t s;
        case (k)
            K_FIRST: s = S_MARK;
            K_HIGH:  s = S_SPAN;
            K_WIN:   s = S_READ;
            default: s = S_READ;
        endcase
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        kind_next        = kind_reg;
        ctr_next         = ctr_reg;
        top_next         = top_reg;
        top_idx_next     = top_idx_reg;
        started_next     = started_reg;
        idx_next         = idx_reg;
        span_next        = span_reg;
        sw_idx_next      = sw_idx_reg;
        sw_cnt_next      = sw_cnt_reg;
        mod_sh_next      = mod_sh_reg;
        mod_rem_next     = mod_rem_reg;
        mod_cnt_next     = mod_cnt_reg;
        res_acc_next     = res_acc_reg;
        res_verdict_next = res_verdict_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp.ready;
        rsp_acc_next     = rsp_acc_reg;
        rsp_verdict_next = rsp_verdict_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = idx_reg;
        ram_wr_data = '0;
        ram_rd_en   = 1'b0;

        case (state_reg)
            S_INIT:
            begin
                // Zero one ring word per cycle after reset
                ram_wr_en   = 1'b1;
                ram_wr_addr = sw_idx_reg;
                sw_idx_next = sw_idx_inc;
                if (sw_idx_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req_fire)
                begin
                    ctr_next   = req.packet_counter;
                    state_next = S_CLASS;
                end
            end

            S_CLASS:
            begin
                span_next    = ctr_word - top_word;
                mod_sh_next  = {{BIT_W{1'b0}}, ctr_word};
                mod_rem_next = '0;
                mod_cnt_next = '0;
                if (!started_reg)
                begin
                    kind_next = K_FIRST;
                end
                else if (ctr_reg > top_reg)
                begin
                    kind_next = K_HIGH;
                end
                else
                begin
                    kind_next = K_WIN;
                end

                if (started_reg && (ctr_reg <= top_reg) && too_old)
                begin
                    // Too old: drop without touching the ring
                    res_acc_next     = 1'b0;
                    res_verdict_next = VERDICT_TOO_OLD;
                    state_next       = S_DONE;
                end
                else if (RING_POW2)
                begin
                    idx_next   = ctr_reg[BIT_W +: IDX_W];
                    state_next = route(kind_next);
                end
                else
                begin
                    state_next = S_MOD;
                end
            end

            S_MOD:
            begin
                mod_sh_next  = mod_sh_step;
                mod_rem_next = mod_rem_step;
                mod_cnt_next = mod_cnt_reg + 1'b1;
                if (mod_cnt_reg == LAST_MCNT)
                begin
                    idx_next   = mod_rem_step;
                    state_next = route(kind_reg);
                end
            end

            S_SPAN:
            begin
                if (span_reg == '0)
                begin
                    // Same word as the old top: just set the bit
                    state_next = S_READ;
                end
                else
                begin
                    // Clear words after the old top's word, whole ring at most
                    sw_idx_next = (top_idx_reg == LAST_IDX) ? '0 : top_idx_reg + 1'b1;
                    if (span_reg >= WNUM_W'(RING_WORDS))
                    begin
                        sw_cnt_next = CNT_W'(RING_WORDS);
                    end
                    else
                    begin
                        sw_cnt_next = span_reg[CNT_W-1:0];
                    end
                    state_next = S_SWEEP;
                end
            end

            S_SWEEP:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = sw_idx_reg;
                sw_idx_next = sw_idx_inc;
                sw_cnt_next = sw_cnt_reg - 1'b1;
                if (sw_cnt_reg == CNT_W'(1))
                begin
                    state_next = S_MARK;
                end
            end

            S_READ:
            begin
                ram_rd_en  = 1'b1;
                state_next = S_RMW;
            end

            S_RMW:
            begin
                if ((kind_reg == K_WIN) && ((ram_rd_data & bit_sel) != '0))
                begin
                    res_acc_next     = 1'b0;
                    res_verdict_next = VERDICT_DUPLICATE;
                end
                else
                begin
                    ram_wr_en    = 1'b1;
                    ram_wr_data  = ram_rd_data | bit_sel;
                    res_acc_next = 1'b1;
                    if (kind_reg == K_HIGH)
                    begin
                        res_verdict_next = VERDICT_NEW_HIGH;
                        top_next         = ctr_reg;
                        top_idx_next     = idx_reg;
                    end
                    else
                    begin
                        res_verdict_next = VERDICT_IN_WINDOW;
                    end
                end
                state_next = S_DONE;
            end

            S_MARK:
            begin
                // Word is known to be zero: write the bit alone
                ram_wr_en        = 1'b1;
                ram_wr_data      = bit_sel;
                res_acc_next     = 1'b1;
                res_verdict_next = (kind_reg == K_FIRST) ? VERDICT_FIRST : VERDICT_NEW_HIGH;
                top_next         = ctr_reg;
                top_idx_next     = idx_reg;
                started_next     = 1'b1;
                state_next       = S_DONE;
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next   = 1'b1;
                    rsp_acc_next     = res_acc_reg;
                    rsp_verdict_next = res_verdict_reg;
                    if (req_fire)
                    begin
                        ctr_next   = req.packet_counter;
                        state_next = S_CLASS;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // State and registered outputs
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_INIT;
            kind_reg        <= K_FIRST;
            ctr_reg         <= '0;
            top_reg         <= '0;
            top_idx_reg     <= '0;
            started_reg     <= 1'b0;
            idx_reg         <= '0;
            span_reg        <= '0;
            sw_idx_reg      <= '0;
            sw_cnt_reg      <= '0;
            mod_sh_reg      <= '0;
            mod_rem_reg     <= '0;
            mod_cnt_reg     <= '0;
            res_acc_reg     <= 1'b0;
            res_verdict_reg <= VERDICT_FIRST;
            rsp_valid_reg   <= 1'b0;
            rsp_acc_reg     <= 1'b0;
            rsp_verdict_reg <= VERDICT_FIRST;
        end
        else
        begin
            state_reg       <= state_next;
            kind_reg        <= kind_next;
            ctr_reg         <= ctr_next;
            top_reg         <= top_next;
            top_idx_reg     <= top_idx_next;
            started_reg     <= started_next;
            idx_reg         <= idx_next;
            span_reg        <= span_next;
            sw_idx_reg      <= sw_idx_next;
            sw_cnt_reg      <= sw_cnt_next;
            mod_sh_reg      <= mod_sh_next;
            mod_rem_reg     <= mod_rem_next;
            mod_cnt_reg     <= mod_cnt_next;
            res_acc_reg     <= res_acc_next;
            res_verdict_reg <= res_verdict_next;
            rsp_valid_reg   <= rsp_valid_next;
            rsp_acc_reg     <= rsp_acc_next;
            rsp_verdict_reg <= rsp_verdict_next;
        end
    end

    // ------------------------------------------------------------------
    // Ring bitmap storage
    // ------------------------------------------------------------------
    arwc_ram #(
        .WIDTH (BITMAP_W),
        .DEPTH (RING_WORDS)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (idx_reg),
        .rd_data (ram_rd_data)
    );

endmodule

>>> verif/tb_anti_replay_window_check_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_anti_replay_window_check_unit: replay filter verification
// Drives packet counters into the window check unit. Each verdict is checked
// against an in-bench model of the sliding window: top counter, baseline
// flag and ring bitmap. The model is updated at every accepted request.
// ----------------------------------------------------------------------------
module tb_anti_replay_window_check_unit import arwc_pkg::*; ();

    localparam int RING_W         = RING_WORDS_DEF;
    localparam int IDLE_LIMIT     = 2000;  // cycles with no transaction on either channel
    localparam int HOLDOFF_CYCLES = 160;   // long receiver stall
    localparam int DRAIN_CYCLES   = 64;    // covers a new high that clears the whole ring
    localparam int HISTORY_DEPTH  = 48;    // recent counters kept for replays

    typedef struct packed {
        logic     accepted;
        verdict_t verdict;
    } verdict_rec_t;

    logic clk = 1'b0;
    logic rst_n;

    arwc_req_if req_ch ();
    arwc_rsp_if rsp_ch ();

    anti_replay_window_check_unit #(
        .RING_WORDS (RING_W)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Window model state: mirrors the block after reset.
    logic [BITMAP_W-1:0] seen_words [RING_W];
    logic [CTR_W-1:0]    top_seen;
    logic                baseline_set;

    verdict_rec_t        pending_verdicts [$];
    logic [CTR_W-1:0]    recent_counters [$];
    verdict_rec_t        expected_rec;

    int unsigned mismatch_count  = 0;
    int unsigned idle_cycles     = 0;
    bit          src_idle_on     = 1'b1;
    bit          sink_idle_on    = 1'b1;
    bit          holdoff_request = 1'b0;

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned ring_slot(input logic [WNUM_W-1:0] word_num);
        return 32'(word_num % WNUM_W'(RING_W));
    endfunction

    // Work out the verdict for one counter and advance the window model.
    function automatic verdict_rec_t judge_counter(input logic [CTR_W-1:0] ctr);
        verdict_rec_t      rec;
        logic [WNUM_W-1:0] prev_top_word;
        logic [WNUM_W-1:0] next_top_word;
        logic [WNUM_W-1:0] span;
        int unsigned       slot;
        int unsigned       k;
        slot = ring_slot(ctr[CTR_W-1:BIT_W]);
        if (!baseline_set)
        begin
            // first packet of the session becomes the baseline, whatever its value
            baseline_set = 1'b1;
            top_seen = ctr;
            seen_words[slot][ctr[BIT_W-1:0]] = 1'b1;
            rec = '{accepted: 1'b1, verdict: VERDICT_FIRST};
        end
        else if (ctr > top_seen)
        begin
            prev_top_word = top_seen[CTR_W-1:BIT_W];
            next_top_word = ctr[CTR_W-1:BIT_W];
            span = next_top_word - prev_top_word;
            if (span >= WNUM_W'(RING_W))
            begin
                // jumped a full ring or more: drop every word
                for (k = 0; k < RING_W; k++)
                    seen_words[k] = '0;
            end
            else
            begin
                // clear words after the old top word up to the new top word
                for (k = 1; k <= span; k++)
                    seen_words[ring_slot(prev_top_word + WNUM_W'(k))] = '0;
            end
            top_seen = ctr;
            seen_words[slot][ctr[BIT_W-1:0]] = 1'b1;
            rec = '{accepted: 1'b1, verdict: VERDICT_NEW_HIGH};
        end
        else if ((top_seen - ctr) >= CTR_W'(WINDOW_SIZE))
            rec = '{accepted: 1'b0, verdict: VERDICT_TOO_OLD};
        else if (seen_words[slot][ctr[BIT_W-1:0]])
            rec = '{accepted: 1'b0, verdict: VERDICT_DUPLICATE};
        else
        begin
            seen_words[slot][ctr[BIT_W-1:0]] = 1'b1;
            rec = '{accepted: 1'b1, verdict: VERDICT_IN_WINDOW};
        end
        return rec;
    endfunction

    // Pick a counter relative to the current top: mostly new highs and
    // in-window traffic, with window edges, replays and random old values.
    function automatic logic [CTR_W-1:0] pick_counter();
        logic [CTR_W-1:0] step;
        logic [CTR_W-1:0] back;
        int unsigned      kind;
        kind = $urandom_range(0, 99);
        if (kind < 30)
            step = CTR_W'($urandom_range(1, BITMAP_W));
        else if (kind < 45)
            step = CTR_W'($urandom_range(BITMAP_W + 1, BITMAP_W * (RING_W + 1)));
        else if (kind < 50)
            step = ({$urandom, $urandom} >> $urandom_range(8, 40)) + 64'd1;
        else
            step = '0;
        if (step != '0)
        begin
            // keep the top far from the counter ceiling until the last test
            if (top_seen[CTR_W-1:CTR_W-2] != 2'b00)
                step = 64'd1;
            return top_seen + step;
        end
        if (kind < 70)
            back = CTR_W'($urandom_range(0, WINDOW_SIZE - 1));
        else if (kind < 78)
            back = CTR_W'($urandom_range(WINDOW_SIZE - 2, WINDOW_SIZE));
        else if (kind < 90 && recent_counters.size() != 0)
            return recent_counters[$urandom_range(0, recent_counters.size() - 1)];
        else
            back = {$urandom, $urandom};
        if (back > top_seen)
            return back % (top_seen + 64'd1);
        return top_seen - back;
    endfunction

    // Offer one counter, wait for the transaction, record the expected verdict.
    // Called and returns at a falling edge; valid stays high for back-to-back items.
    task automatic send_counter(input logic [CTR_W-1:0] ctr);
        if (src_idle_on && ($urandom_range(0, 3) == 0))
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.packet_counter <= ctr;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_verdicts.push_back(judge_counter(ctr));
        recent_counters.push_back(ctr);
        if (recent_counters.size() > HISTORY_DEPTH)
            void'(recent_counters.pop_front());
        @(negedge clk);
    endtask

    // Drop valid and hold the sender until every verdict has come back.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_verdicts.size() != 0);
    endtask

    // Baseline at zero, a repeat of the top, small new highs, stale-word replays.
    task automatic test_baseline();
        send_counter(64'd0);
        send_counter(64'd0);
        send_counter(64'd1);
        send_counter(64'd1);
        send_counter(64'd0);
        send_counter(64'd63);
        send_counter(64'd64);
        send_counter(64'd40);
        send_counter(64'd40);
    endtask

    // Top at 2000: 16 is exactly one window behind, 17 is the oldest in window.
    task automatic test_window_edge();
        send_counter(64'd2000);
        send_counter(64'd16);
        send_counter(64'd17);
        send_counter(64'd17);
        send_counter(64'd10);
    endtask

    // Advance 31 words (partial clear keeps the old top word), then 32 words
    // (whole ring cleared), then probe both sides of the window edge.
    task automatic test_ring_clear();
        send_counter(64'(62 * BITMAP_W + 5));
        send_counter(64'd2000);
        send_counter(64'(94 * BITMAP_W + 7));
        send_counter(64'(94 * BITMAP_W + 7 - (WINDOW_SIZE - 1)));
        send_counter(64'(94 * BITMAP_W + 7 - WINDOW_SIZE));
    endtask

    task automatic test_random_traffic(input int unsigned count);
        repeat (count)
            send_counter(pick_counter());
    endtask

    // Stall the verdict channel for a long stretch while requests keep coming,
    // so the block fills and holds off its input.
    task automatic test_output_holdoff();
        holdoff_request = 1'b1;
        repeat (40)
            send_counter(pick_counter());
        while (holdoff_request)
            @(negedge clk);
    endtask

    task automatic test_sender_pause();
        repeat (3)
        begin
            repeat (12)
                send_counter(pick_counter());
            wait_drained();
        end
    endtask

    // Full-speed stretch with no idling on either side.
    task automatic test_full_rate();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        repeat (40)
            send_counter(pick_counter());
    endtask

    // Jump to the largest counter and check the window just below it.
    task automatic test_counter_ceiling();
        send_counter('1);
        send_counter('1);
        send_counter('1 - 64'(WINDOW_SIZE));
        send_counter('1 - 64'(WINDOW_SIZE - 1));
        send_counter('1 - 64'd1);
    endtask

    // Stimulus sequence
    initial
    begin
        int unsigned k;
        rst_n = 1'b0;
        req_ch.valid          <= 1'b0;
        req_ch.packet_counter <= '0;
        for (k = 0; k < RING_W; k++)
            seen_words[k] = '0;
        top_seen     = '0;
        baseline_set = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_baseline();
        test_window_edge();
        test_ring_clear();
        test_random_traffic(320);
        test_output_holdoff();
        test_sender_pause();
        test_full_rate();
        test_counter_ceiling();

        // Wait for the last verdicts, then give the block time to show extras.
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && pending_verdicts.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Verdict receiver: random ready bursts, plus one long hold-off on request.
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (holdoff_request)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLDOFF_CYCLES - 1) @(negedge clk);
                holdoff_request = 1'b0;
            end
            else if (sink_idle_on && ($urandom_range(0, 4) == 0))
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 6) - 1) @(negedge clk);
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // Compare each verdict transaction with the oldest expectation.
    always @(posedge clk)
    begin
        if (rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected verdict: actual accepted=%0b verdict=%0d",
                         $time, rsp_ch.accepted, rsp_ch.verdict);
            end
            else
            begin
                expected_rec = pending_verdicts.pop_front();
                if (rsp_ch.accepted !== expected_rec.accepted ||
                    rsp_ch.verdict !== expected_rec.verdict)
                begin
                    mismatch_count++;
                    $display("%0t: expected acc=%0b verdict=%0d, actual acc=%0b verdict=%0d",
                             $time, expected_rec.accepted, expected_rec.verdict,
                             rsp_ch.accepted, rsp_ch.verdict);
                end
            end
        end
    end

    // Watchdog: end the run if no transaction moves for too long.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule

>>> filelist.f
rtl/arwc_pkg.sv
rtl/arwc_req_if.sv
rtl/arwc_rsp_if.sv
rtl/arwc_ram.sv
rtl/anti_replay_window_check_unit.sv
verif/tb_anti_replay_window_check_unit.sv
